// File: rtl/dq_pkg.sv
// Package for the double-ended queue: field widths, request and status codes,
// the sequencer state type and the command and status bundles between modules.
// Depends on nothing; every other file of the block uses it.
package dq_pkg;

  localparam int DEPTH_DEF = 16;

  localparam int MODE_W    = 3;
  localparam int WORD_W    = 32;
  localparam int STATUS_W  = 2;
  localparam int ENTRIES_W = 5;

  // Packed result word: popped, entries, front, end; padded to whole bytes.
  localparam int OUT_BITS   = WORD_W + ENTRIES_W + WORD_W + WORD_W;
  localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

  typedef logic signed [WORD_W-1:0] word_t;

  localparam logic [MODE_W-1:0] MODE_PUSH_FRONT = 3'd0;
  localparam logic [MODE_W-1:0] MODE_PUSH_END   = 3'd1;
  localparam logic [MODE_W-1:0] MODE_POP_FRONT  = 3'd2;
  localparam logic [MODE_W-1:0] MODE_POP_END    = 3'd3;

  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_UNDERFLOW = 2'd1;
  localparam logic [STATUS_W-1:0] ST_OVERFLOW  = 2'd2;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_LOOK,
    S_LOAD
  } dq_state_e;

  // Commands from the sequencer to the datapath.
  typedef struct packed {
    logic take;  // latch the incoming request
    logic exec;  // apply the request to pointers and store
    logic look;  // read front and end words
    logic load;  // move the result into the output register
  } dq_cmd_t;

  // Status from the datapath to the sequencer.
  typedef struct packed {
    logic out_free;  // output register can take a new result this cycle
  } dq_stat_t;

endpackage

// File: rtl/double_ended_queue.sv
// Top level of the double-ended queue: request stream in, result stream out.
// Depends on dq_pkg, dq_ctrl and dq_datapath.
//
// Usage: each request on the slave stream carries a mode in s_axis_tuser
// (push front, push end, pop front, pop end, or query) and a word in
// s_axis_tdata. Every request produces exactly one result on the master
// stream: the popped word, a status in m_axis_tuser (ok, underflow on a pop
// from an empty queue, overflow on a push into a full queue), the entry
// count, and the front and end words after the request.
// The accepting edge latches the request; the execute step then updates the
// pointers and writes or reads the ring store, the look-up step reads the new
// front and end words through the two registered read ports, and the load
// step loads the output register. The sequencer takes no new request while
// one is being worked on: it accepts again once the load has brought it back
// to idle, after its four steps of idle, execute, look-up and load.
// The output register holds a finished result while the receiver stalls, and
// the next request is still accepted and worked on meanwhile; it waits only
// in its final step until the held result has been taken.
// Reset empties the queue and clears the output valid. The store contents
// are not cleared; only written entries are ever shown.
module double_ended_queue #(
  parameter int DEPTH = dq_pkg::DEPTH_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // Bits from low up: value[31:0].
  input  logic [dq_pkg::WORD_W-1:0]         s_axis_tdata,
  // Bits from low up: mode[2:0].
  input  logic [dq_pkg::MODE_W-1:0]         s_axis_tuser,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // Bits from low up: popped_word[31:0], entries[36:32], front_word[68:37],
  // end_word[100:69], zero padding[103:101].
  output logic [dq_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
  // Bits from low up: status[1:0].
  output logic [dq_pkg::STATUS_W-1:0]       m_axis_tuser
);

  dq_pkg::dq_cmd_t  cmd;
  dq_pkg::dq_stat_t stat;

  dq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  dq_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .mode_i       (s_axis_tuser),
    .value_i      (dq_pkg::word_t'(s_axis_tdata)),
    .out_ready_i  (m_axis_tready),
    .out_valid_o  (m_axis_tvalid),
    .out_data_o   (m_axis_tdata),
    .out_status_o (m_axis_tuser)
  );

endmodule

// File: rtl/dq_ctrl.sv
// Sequencer of the double-ended queue: steps each request through execute,
// look-up and output load. Depends on dq_pkg.
module dq_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  dq_pkg::dq_stat_t stat_i,
  output dq_pkg::dq_cmd_t  cmd_o
);

  dq_pkg::dq_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= dq_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      dq_pkg::S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.take = 1'b1;
          state_d    = dq_pkg::S_EXEC;
        end
      end
      dq_pkg::S_EXEC: begin
        cmd_o.exec = 1'b1;
        state_d    = dq_pkg::S_LOOK;
      end
      dq_pkg::S_LOOK: begin
        cmd_o.look = 1'b1;
        state_d    = dq_pkg::S_LOAD;
      end
      dq_pkg::S_LOAD: begin
        // Wait here while the previous result is still held downstream.
        if (stat_i.out_free) begin
          cmd_o.load = 1'b1;
          state_d    = dq_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = dq_pkg::S_IDLE;
      end
    endcase
  end

endmodule

// File: rtl/dq_datapath.sv
// Datapath of the double-ended queue: ring store, front pointer, entry count
// and the output register. Depends on dq_pkg; driven by dq_ctrl commands.
module dq_datapath #(
  parameter int DEPTH = dq_pkg::DEPTH_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  dq_pkg::dq_cmd_t                    cmd_i,
  output dq_pkg::dq_stat_t                   stat_o,
  input  logic [dq_pkg::MODE_W-1:0]          mode_i,
  input  dq_pkg::word_t                      value_i,
  input  logic                               out_ready_i,
  output logic                               out_valid_o,
  output logic [dq_pkg::OUT_DATA_W-1:0]      out_data_o,
  output logic [dq_pkg::STATUS_W-1:0]        out_status_o
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W:0]   DEPTH_X  = (PTR_W + 1)'(DEPTH);
  localparam logic [CNT_W-1:0] DEPTH_C  = CNT_W'(DEPTH);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam int PAD_W = dq_pkg::OUT_DATA_W - dq_pkg::OUT_BITS;

  // Request and queue state.
  logic [dq_pkg::MODE_W-1:0] mode_q;
  dq_pkg::word_t             value_q;
  logic [PTR_W-1:0]          front_q;
  logic [CNT_W-1:0]          cnt_q;
  logic [dq_pkg::STATUS_W-1:0] status_q, status_d;
  logic                      pop_ok_q;
  dq_pkg::word_t             popped_q;

  // Ring store and its two registered read ports.
  dq_pkg::word_t mem [DEPTH];
  dq_pkg::word_t rd_a_q, rd_b_q;
  logic [PTR_W-1:0] ra, rb, wa;
  logic             we;

  // Output register.
  logic                          out_valid_q;
  dq_pkg::word_t                 out_popped_q, out_front_q, out_end_q;
  logic [dq_pkg::ENTRIES_W-1:0]  out_entries_q;
  logic [dq_pkg::STATUS_W-1:0]   out_status_q;

  logic is_push, is_pop, full, empty;
  logic [PTR_W:0]   front_x, cnt_x, tail_sum, end_sum;
  logic [PTR_W-1:0] front_dec, front_inc, tail_pos, end_pos;

  assign is_push = (mode_q == dq_pkg::MODE_PUSH_FRONT) || (mode_q == dq_pkg::MODE_PUSH_END);
  assign is_pop  = (mode_q == dq_pkg::MODE_POP_FRONT) || (mode_q == dq_pkg::MODE_POP_END);
  assign full    = (cnt_q == DEPTH_C);
  assign empty   = (cnt_q == '0);

  // Ring positions; every offset is at most DEPTH, so one conditional subtract wraps.
  assign front_x   = {1'b0, front_q};
  assign cnt_x     = (PTR_W + 1)'(cnt_q);
  assign tail_sum  = front_x + cnt_x;
  assign end_sum   = tail_sum - (PTR_W + 1)'(1);
  assign tail_pos  = (tail_sum >= DEPTH_X) ? PTR_W'(tail_sum - DEPTH_X) : tail_sum[PTR_W-1:0];
  assign end_pos   = (end_sum >= DEPTH_X) ? PTR_W'(end_sum - DEPTH_X) : end_sum[PTR_W-1:0];
  assign front_dec = (front_q == '0) ? LAST_PTR : front_q - PTR_W'(1);
  assign front_inc = (front_q == LAST_PTR) ? '0 : front_q + PTR_W'(1);

  always_comb begin
    status_d = dq_pkg::ST_OK;
    if (is_push && full) begin
      status_d = dq_pkg::ST_OVERFLOW;
    end else if (is_pop && empty) begin
      status_d = dq_pkg::ST_UNDERFLOW;
    end
  end

  assign we = cmd_i.exec && is_push && !full;
  assign wa = (mode_q == dq_pkg::MODE_PUSH_FRONT) ? front_dec : tail_pos;
  // During execute port A fetches the word being popped; during look-up the new front.
  assign ra = (cmd_i.exec && mode_q == dq_pkg::MODE_POP_END) ? end_pos : front_q;
  assign rb = end_pos;

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[wa] <= value_q;
    end
    if (cmd_i.exec || cmd_i.look) begin
      rd_a_q <= mem[ra];
      rd_b_q <= mem[rb];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.take) begin
      mode_q  <= mode_i;
      value_q <= value_i;
    end
    if (cmd_i.exec) begin
      status_q <= status_d;
      pop_ok_q <= is_pop && !empty;
    end
    if (cmd_i.look) begin
      popped_q <= pop_ok_q ? rd_a_q : '0;
    end
    if (cmd_i.load) begin
      out_popped_q  <= popped_q;
      out_status_q  <= status_q;
      out_entries_q <= dq_pkg::ENTRIES_W'(cnt_q);
      out_front_q   <= empty ? '0 : rd_a_q;
      out_end_q     <= empty ? '0 : rd_b_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      front_q     <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.exec) begin
        if (we) begin
          cnt_q <= cnt_q + CNT_W'(1);
          if (mode_q == dq_pkg::MODE_PUSH_FRONT) begin
            front_q <= front_dec;
          end
        end else if (is_pop && !empty) begin
          cnt_q <= cnt_q - CNT_W'(1);
          if (mode_q == dq_pkg::MODE_POP_FRONT) begin
            front_q <= front_inc;
          end
        end
      end
      if (cmd_i.load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign stat_o.out_free = !out_valid_q || out_ready_i;
  assign out_valid_o     = out_valid_q;
  assign out_status_o    = out_status_q;
  assign out_data_o      = {{PAD_W{1'b0}}, out_end_q, out_front_q, out_entries_q, out_popped_q};

`ifndef ASSERT_OFF
  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= DEPTH_C)
    else $error("entry count exceeds the store depth");

  a_front_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    front_q <= LAST_PTR)
    else $error("front pointer left the ring");

  a_pop_count : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.exec && is_pop && !empty |=> cnt_q == $past(cnt_q) - CNT_W'(1))
    else $error("successful pop did not decrement the count");

  a_overflow_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load && status_q == dq_pkg::ST_OVERFLOW
      |=> out_entries_q == dq_pkg::ENTRIES_W'(DEPTH))
    else $error("overflow reported while the store was not full");
`endif

endmodule
